/* src/probe_signal_lookup_defines.svh */
// Assertion macros shared by the probe signal lookup checker.
`ifndef PROBE_SIGNAL_LOOKUP_DEFINES_SVH
`define PROBE_SIGNAL_LOOKUP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PSL_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("probe_signal_lookup: implication failed");

// Next-cycle implication, checked outside reset.
`define PSL_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("probe_signal_lookup: next-cycle implication failed");

// Property that must hold in the cycle after reset is sampled active.
`define PSL_ASSERT_RST(label, cons) \
    label: assert property (@(posedge aclk) (!aresetn) |=> (cons)) \
        else $error("probe_signal_lookup: reset value wrong");

`endif

/* src/psl_pkg.sv */
// Types and constants of the probe signal lookup block.
package psl_pkg;

    // Operation codes of an input transaction
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Probe type that looks up only the unmethylated address
    localparam logic [1:0] PT_TYPE2 = 2'd2;

    // Saturation value of the miss counter
    localparam logic [23:0] MISS_MAX = 24'hFF_FFFF;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] entry_address;
        logic [15:0] green_mean;
        logic [15:0] red_mean;
        logic [7:0]  green_beads;
        logic [7:0]  red_beads;
        logic [1:0]  probe_type;
        logic [31:0] meth_address;
        logic [31:0] unmeth_address;
    } in_item_t;

    typedef struct packed {
        logic [15:0] meth_green;
        logic [15:0] meth_red;
        logic [15:0] unmeth_green;
        logic [15:0] unmeth_red;
        logic        meth_present;
        logic        unmeth_present;
        logic        address_missing;
        logic        probe_masked;
        logic [23:0] missing_total;
    } out_item_t;

endpackage

/* src/psl_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module psl_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* src/probe_signal_lookup.sv */
// Top level: sorted address table in RAM, searched by bisection for probe signals.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+------------------------------
//   s_      | in        | s_valid / s_ready   | in_item_t (load, query, clear)
//   m_      | out       | m_valid / m_ready   | out_item_t (one per query)
//   cfg_    | in        | cfg_valid/cfg_ready | min_bead_count (8 bits)
//
// Loads and clears are handled in ST_IDLE. A query runs ST_START and ST_SEARCH per search,
// then posts the result in ST_FINISH; a search does one RAM read per cycle, at most
// floor(log2(entries)) + 1 reads (type II: the unmethylated search only), since the single
// RAM read port allows one probe per cycle.
// Synchronous active-low reset; the table needs no clearing pass. A stalled result
// waits in the output register while loads and clears go on; a query waits at its end.
module probe_signal_lookup
    import psl_pkg::*;
#(
    parameter int TABLE_DEPTH = 65536
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic [7:0] cfg_data
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

    typedef struct packed {
        logic [31:0] address;
        logic [15:0] green_mean;
        logic [15:0] red_mean;
        logic [7:0]  green_beads;
        logic [7:0]  red_beads;
    } entry_t;

    typedef enum logic [1:0] {ST_IDLE, ST_START, ST_SEARCH, ST_FINISH} state_t;

    // Control registers
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [23:0]        miss_cnt_reg, miss_cnt_next;
    logic [7:0]         min_bead_reg, min_bead_next;
    logic               meth_phase_reg, meth_phase_next;
    logic               mfound_reg, mfound_next;
    logic               ufound_reg, ufound_next;
    logic               miss_reg, miss_next;
    logic               low_reg, low_next;
    logic               m_valid_reg, m_valid_next;

    // Payload registers
    logic [31:0]        maddr_reg, maddr_next;
    logic [31:0]        uaddr_reg, uaddr_next;
    logic [CNT_W-1:0]   lo_reg, lo_next;
    logic [CNT_W-1:0]   hi_reg, hi_next;
    logic [CNT_W-1:0]   mid_reg, mid_next;
    logic [15:0]        mg_reg, mg_next;
    logic [15:0]        mr_reg, mr_next;
    logic [15:0]        ug_reg, ug_next;
    logic [15:0]        ur_reg, ur_next;
    out_item_t          m_data_reg, m_data_next;

    // RAM port signals
    logic                     ram_we;
    logic                     ram_re;
    logic [IDX_W-1:0]         ram_raddr;
    logic [$bits(entry_t)-1:0] ram_rdata;
    entry_t                   wr_entry;
    entry_t                   rd_entry;

    // Search datapath
    logic [31:0]      key;
    logic             hit;
    logic             less;
    logic             bead_low;
    logic [CNT_W-1:0] lo_up;
    logic [CNT_W-1:0] mid_low_half;
    logic [CNT_W-1:0] mid_high_half;
    logic [CNT_W-1:0] mid_first;
    logic             srch_done;
    logic             srch_found;
    logic [23:0]      miss_cnt_upd;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Build the entry written by a load
    always_comb begin
        wr_entry.address     = s_data.entry_address;
        wr_entry.green_mean  = s_data.green_mean;
        wr_entry.red_mean    = s_data.red_mean;
        wr_entry.green_beads = s_data.green_beads;
        wr_entry.red_beads   = s_data.red_beads;
    end

    psl_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (wr_entry),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_entry = entry_t'(ram_rdata);

    // Compare the probed entry and precompute both candidate midpoints
    assign key           = meth_phase_reg ? maddr_reg : uaddr_reg;
    assign hit           = (rd_entry.address == key);
    assign less          = (rd_entry.address < key);
    assign bead_low      = (min_bead_reg != 8'd0) &&
                           ((rd_entry.green_beads < min_bead_reg) ||
                            (rd_entry.red_beads < min_bead_reg));
    assign lo_up         = mid_reg + CNT_ONE;
    assign mid_low_half  = lo_reg + ((mid_reg - lo_reg - CNT_ONE) >> 1);
    assign mid_high_half = lo_up + ((hi_reg - lo_up - CNT_ONE) >> 1);
    assign mid_first     = (count_reg - CNT_ONE) >> 1;

    // Saturating miss count for the finishing query
    assign miss_cnt_upd = (miss_reg && (miss_cnt_reg != MISS_MAX)) ?
                          miss_cnt_reg + 24'd1 : miss_cnt_reg;

    // Next-state logic
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        miss_cnt_next   = miss_cnt_reg;
        min_bead_next   = cfg_valid ? cfg_data : min_bead_reg;
        meth_phase_next = meth_phase_reg;
        mfound_next     = mfound_reg;
        ufound_next     = ufound_reg;
        miss_next       = miss_reg;
        low_next        = low_reg;
        m_valid_next    = m_valid_reg;
        maddr_next      = maddr_reg;
        uaddr_next      = uaddr_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        mg_next         = mg_reg;
        mr_next         = mr_reg;
        ug_next         = ug_reg;
        ur_next         = ur_reg;
        m_data_next     = m_data_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_raddr       = mid_first[IDX_W-1:0];
        srch_done       = 1'b0;
        srch_found      = 1'b0;

        // Drop the result once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_data.operation)
                        OP_LOAD: begin
                            if (count_reg < DEPTH_CNT) begin
                                ram_we     = 1'b1;
                                count_next = count_reg + CNT_ONE;
                            end
                        end
                        OP_QUERY: begin
                            maddr_next      = s_data.meth_address;
                            uaddr_next      = s_data.unmeth_address;
                            meth_phase_next = (s_data.probe_type != PT_TYPE2);
                            mfound_next     = 1'b0;
                            ufound_next     = 1'b0;
                            miss_next       = 1'b0;
                            low_next        = 1'b0;
                            mg_next         = 16'd0;
                            mr_next         = 16'd0;
                            ug_next         = 16'd0;
                            ur_next         = 16'd0;
                            state_next      = ST_START;
                        end
                        OP_CLEAR: begin
                            count_next    = '0;
                            miss_cnt_next = 24'd0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_START: begin
                // Open the range [0, count) and probe its middle
                lo_next = '0;
                hi_next = count_reg;
                if ((key == 32'd0) || (count_reg == '0)) begin
                    srch_done = 1'b1;
                end else begin
                    mid_next   = mid_first;
                    ram_re     = 1'b1;
                    ram_raddr  = mid_first[IDX_W-1:0];
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                // Narrow the range, or stop on a hit or an empty range
                if (hit) begin
                    srch_done  = 1'b1;
                    srch_found = 1'b1;
                end else if (less) begin
                    if (lo_up < hi_reg) begin
                        lo_next   = lo_up;
                        mid_next  = mid_high_half;
                        ram_re    = 1'b1;
                        ram_raddr = mid_high_half[IDX_W-1:0];
                    end else begin
                        srch_done = 1'b1;
                    end
                end else begin
                    if (lo_reg < mid_reg) begin
                        hi_next   = mid_reg;
                        mid_next  = mid_low_half;
                        ram_re    = 1'b1;
                        ram_raddr = mid_low_half[IDX_W-1:0];
                    end else begin
                        srch_done = 1'b1;
                    end
                end
            end
            ST_FINISH: begin
                // Post the result once the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_data_next.meth_green      = mg_reg;
                    m_data_next.meth_red        = mr_reg;
                    m_data_next.unmeth_green    = ug_reg;
                    m_data_next.unmeth_red      = ur_reg;
                    m_data_next.meth_present    = mfound_reg;
                    m_data_next.unmeth_present  = ufound_reg;
                    m_data_next.address_missing = miss_reg;
                    m_data_next.probe_masked    = low_reg ||
                                                  (miss_reg && (min_bead_reg != 8'd0));
                    m_data_next.missing_total   = miss_cnt_upd;
                    miss_cnt_next               = miss_cnt_upd;
                    m_valid_next                = 1'b1;
                    state_next                  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Record the outcome of a finished search and move to the next one
        if (srch_done) begin
            if (meth_phase_reg) begin
                mfound_next = srch_found;
                if (srch_found) begin
                    mg_next = rd_entry.green_mean;
                    mr_next = rd_entry.red_mean;
                end
            end else begin
                ufound_next = srch_found;
                if (srch_found) begin
                    ug_next = rd_entry.green_mean;
                    ur_next = rd_entry.red_mean;
                end
            end
            low_next        = low_reg || (srch_found && bead_low);
            miss_next       = miss_reg || !srch_found;
            meth_phase_next = 1'b0;
            state_next      = meth_phase_reg ? ST_START : ST_FINISH;
        end
    end

    // State and control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            miss_cnt_reg   <= 24'd0;
            min_bead_reg   <= 8'd0;
            meth_phase_reg <= 1'b0;
            mfound_reg     <= 1'b0;
            ufound_reg     <= 1'b0;
            miss_reg       <= 1'b0;
            low_reg        <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            miss_cnt_reg   <= miss_cnt_next;
            min_bead_reg   <= min_bead_next;
            meth_phase_reg <= meth_phase_next;
            mfound_reg     <= mfound_next;
            ufound_reg     <= ufound_next;
            miss_reg       <= miss_next;
            low_reg        <= low_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        maddr_reg  <= maddr_next;
        uaddr_reg  <= uaddr_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        mg_reg     <= mg_next;
        mr_reg     <= mr_next;
        ug_reg     <= ug_next;
        ur_reg     <= ur_next;
        m_data_reg <= m_data_next;
    end

endmodule

/* src/psl_checker.sv */
// Port-level checker for the probe signal lookup block, bound to the top level.
`include "probe_signal_lookup_defines.svh"

module psl_checker
    import psl_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    // Hold a stalled result
    `PSL_ASSERT_NXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data))

    // Zero methylated signals when the lookup was not found
    `PSL_ASSERT_IMP(a_meth_zero, m_valid && !m_data.meth_present, (m_data.meth_green == 16'd0) && (m_data.meth_red == 16'd0))

    // Zero unmethylated signals, and flag a miss, when that lookup was not found
    `PSL_ASSERT_IMP(a_unmeth_miss, m_valid && !m_data.unmeth_present, m_data.address_missing && (m_data.unmeth_green == 16'd0) && (m_data.unmeth_red == 16'd0))

    // A missing address never leaves the running total at zero
    `PSL_ASSERT_IMP(a_total_counts, m_valid && m_data.address_missing, m_data.missing_total != 24'd0)

    // No result straight out of reset
    `PSL_ASSERT_RST(a_reset_idle, !m_valid)

endmodule

bind probe_signal_lookup psl_checker u_psl_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

/* verif/psl_check_pkg.sv */
// Scoreboard for the probe signal lookup block: signal predictor and result check.
package psl_check_pkg;
    import psl_pkg::*;

    // Codes the block ignores or treats as type I
    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam logic [1:0] PT_GREEN   = 2'd0;
    localparam logic [1:0] PT_RED     = 2'd1;
    localparam logic [1:0] PT_UNKNOWN = 2'd3;

    localparam int TABLE_ENTRIES = 65536;

    typedef struct packed {
        logic [31:0] address;
        logic [15:0] green_mean;
        logic [15:0] red_mean;
        logic [7:0]  green_beads;
        logic [7:0]  red_beads;
    } entry_t;

    class lookup_scoreboard;
        entry_t     entries[$];
        logic [7:0] bead_floor;
        logic [23:0] miss_count;
        out_item_t  pending_signals[$];
        int errors;
        int loads;
        int dropped;
        int clears;
        int queries;
        int misses;
        int masked;

        function new();
            bead_floor = '0;
            miss_count = '0;
            errors = 0;
            loads = 0;
            dropped = 0;
            clears = 0;
            queries = 0;
            misses = 0;
            masked = 0;
        endfunction

        // Bisect the stored entries in load order; address zero never matches
        function bit bisect(logic [31:0] key, output int idx);
            int lo;
            int hi;
            int mid;
            idx = 0;
            lo = 0;
            hi = entries.size();
            if (key == '0) return 1'b0;
            while (lo < hi) begin
                mid = lo + (hi - lo - 1) / 2;
                if (entries[mid].address == key) begin
                    idx = mid;
                    return 1'b1;
                end
                if (entries[mid].address < key) lo = mid + 1;
                else hi = mid;
            end
            return 1'b0;
        endfunction

        function bit short_beads(int idx);
            return bead_floor != '0 &&
                   (entries[idx].green_beads < bead_floor ||
                    entries[idx].red_beads < bead_floor);
        endfunction

        // Update the table copy and queue the signals a query produces
        function void note_item(in_item_t item);
            out_item_t res;
            int idx;
            bit found;
            bit miss;
            bit low;
            case (item.operation)
                OP_LOAD: begin
                    if (entries.size() < TABLE_ENTRIES) begin
                        entries.push_back('{item.entry_address, item.green_mean,
                                            item.red_mean, item.green_beads,
                                            item.red_beads});
                        loads++;
                    end else begin
                        dropped++;
                    end
                end
                OP_CLEAR: begin
                    entries.delete();
                    miss_count = '0;
                    clears++;
                end
                OP_QUERY: begin
                    res = '0;
                    miss = 1'b0;
                    low = 1'b0;
                    if (item.probe_type != PT_TYPE2) begin
                        found = bisect(item.meth_address, idx);
                        res.meth_present = found;
                        if (found) begin
                            res.meth_green = entries[idx].green_mean;
                            res.meth_red = entries[idx].red_mean;
                            low = low | short_beads(idx);
                        end else begin
                            miss = 1'b1;
                        end
                    end
                    found = bisect(item.unmeth_address, idx);
                    res.unmeth_present = found;
                    if (found) begin
                        res.unmeth_green = entries[idx].green_mean;
                        res.unmeth_red = entries[idx].red_mean;
                        low = low | short_beads(idx);
                    end else begin
                        miss = 1'b1;
                    end
                    if (miss && miss_count != MISS_MAX) miss_count++;
                    res.address_missing = miss;
                    res.probe_masked = low || (miss && bead_floor != '0);
                    res.missing_total = miss_count;
                    pending_signals.push_back(res);
                    queries++;
                    misses += miss;
                    masked += res.probe_masked;
                end
                default: ;
            endcase
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            end
        endfunction

        // Match one result against the oldest queued query
        function void check_result(out_item_t got);
            out_item_t want;
            if (pending_signals.size() == 0) begin
                errors++;
                $display("%0t: result expected none, got %h", $time, got);
                return;
            end
            want = pending_signals.pop_front();
            compare_field("meth_green", want.meth_green, got.meth_green);
            compare_field("meth_red", want.meth_red, got.meth_red);
            compare_field("unmeth_green", want.unmeth_green, got.unmeth_green);
            compare_field("unmeth_red", want.unmeth_red, got.unmeth_red);
            compare_field("meth_present", want.meth_present, got.meth_present);
            compare_field("unmeth_present", want.unmeth_present, got.unmeth_present);
            compare_field("address_missing", want.address_missing, got.address_missing);
            compare_field("probe_masked", want.probe_masked, got.probe_masked);
            compare_field("missing_total", want.missing_total, got.missing_total);
        endfunction
    endclass

endpackage

/* verif/probe_signal_lookup_test.sv */
// Top of the probe signal lookup testbench: clock, reset, drivers, phases and watchdog.
module probe_signal_lookup_test;
    timeunit 1ns;
    timeprecision 1ps;

    import psl_pkg::*;
    import psl_check_pkg::*;

    localparam int IDLE_LIMIT      = 5000;
    localparam int DRAIN_CYCLES    = 64;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int RANDOM_ITEMS    = 600;
    localparam int QUIET_ITEMS     = 100;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    in_item_t   s_data = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    out_item_t  m_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data = '0;

    lookup_scoreboard sb = new();
    bit idling_on = 1'b1;
    bit hold_off_request = 1'b0;
    int stall_left = 0;
    int quiet_cycles = 0;
    int random_items = 0;
    int cfg_writes = 0;

    probe_signal_lookup i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    // Drive result ready: random stall bursts, or one long hold-off on request
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (hold_off_request) begin
            hold_off_request = 1'b0;
            stall_left = HOLD_OFF_CYCLES - 1;
            m_ready <= 1'b0;
        end else if (idling_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 17);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Check each result transaction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
    end

    // End the run when no transaction moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic in_item_t noise_item();
        logic [159:0] bits;
        bits = {$urandom, $urandom, $urandom, $urandom, $urandom};
        return bits[$bits(in_item_t)-1:0];
    endfunction

    function automatic in_item_t load_item(logic [31:0] address, logic [15:0] green,
                                           logic [15:0] red, logic [7:0] gbeads,
                                           logic [7:0] rbeads);
        in_item_t item;
        item = noise_item();
        item.operation = OP_LOAD;
        item.entry_address = address;
        item.green_mean = green;
        item.red_mean = red;
        item.green_beads = gbeads;
        item.red_beads = rbeads;
        return item;
    endfunction

    function automatic in_item_t random_load(logic [31:0] address);
        return load_item(address, 16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
    endfunction

    function automatic in_item_t query_item(logic [1:0] ptype, logic [31:0] meth,
                                            logic [31:0] unmeth);
        in_item_t item;
        item = noise_item();
        item.operation = OP_QUERY;
        item.probe_type = ptype;
        item.meth_address = meth;
        item.unmeth_address = unmeth;
        return item;
    endfunction

    function automatic in_item_t clear_item();
        in_item_t item;
        item = noise_item();
        item.operation = OP_CLEAR;
        return item;
    endfunction

    function automatic in_item_t ignored_item();
        in_item_t item;
        item = noise_item();
        item.operation = OP_UNUSED;
        return item;
    endfunction

    // Mostly stored addresses, some neighbors, zeros and random misses
    function automatic logic [31:0] pick_address();
        int r;
        int n;
        r = $urandom_range(0, 99);
        n = sb.entries.size();
        if (n > 0 && r < 70) return sb.entries[$urandom_range(0, n - 1)].address;
        if (r < 80) return '0;
        if (n > 0 && r < 90) return sb.entries[$urandom_range(0, n - 1)].address + 32'd1;
        return $urandom;
    endfunction

    function automatic logic [1:0] pick_type();
        if ($urandom_range(0, 9) == 0) return PT_UNKNOWN;
        return 2'($urandom_range(0, 2));
    endfunction

    // Offer one transaction from a falling edge; return at the falling edge after accept
    task automatic send_item(in_item_t item);
        if (idling_on && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= item;
        do @(posedge aclk); while (!s_ready);
        sb.note_item(item);
        @(negedge aclk);
    endtask

    task automatic write_bead_floor(logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        sb.bead_floor = value;
        cfg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Drop valid, wait for every queued result, then let loads and clears finish
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending_signals.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Append ascending unique addresses spread over the full range
    task automatic load_sorted(int n);
        longint unsigned addr_next;
        longint unsigned span;
        int i;
        addr_next = 0;
        for (i = 0; i < n; i++) begin
            span = (64'hFFFF_FFFF - addr_next) / (n - i);
            if (span == 0) break;
            addr_next += $urandom_range(1, 32'(span));
            send_item(random_load(32'(addr_next)));
            random_items++;
        end
    endtask

    // Append addresses in no order, with repeats in a narrow range
    task automatic load_scrambled(int n);
        int i;
        for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 1) == 0) send_item(random_load($urandom_range(1, 64)));
            else send_item(random_load($urandom));
            random_items++;
        end
    endtask

    // Queries with a few stray loads, clears and ignored codes mixed in
    task automatic run_queries(int count);
        int i;
        int r;
        for (i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 4) begin
                send_item(ignored_item());
            end else begin
                if (r < 7) send_item(random_load(pick_address()));
                else if (r < 8) send_item(clear_item());
                else send_item(query_item(pick_type(), pick_address(), pick_address()));
                random_items++;
            end
        end
    endtask

    initial begin
        int i;
        int n;
        int r;
        int phase;
        logic [7:0] setting;

        // Hold reset, then release at a falling edge
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        write_bead_floor(8'd0);

        // Empty table, zero addresses, field extremes and an address-zero entry
        send_item(query_item(PT_GREEN, 32'd5, 32'd6));
        send_item(query_item(PT_TYPE2, 32'd0, 32'd0));
        send_item(load_item(32'd0, 16'h0001, 16'h0002, 8'd3, 8'd4));
        send_item(load_item(32'd1, 16'hFFFF, 16'h0000, 8'd255, 8'd0));
        send_item(load_item(32'h8000_0000, 16'h0000, 16'hFFFF, 8'd0, 8'd255));
        send_item(load_item(32'hFFFF_FFFF, 16'h1234, 16'hABCD, 8'd10, 8'd200));
        send_item(query_item(PT_GREEN, 32'd1, 32'hFFFF_FFFF));
        send_item(query_item(PT_RED, 32'h8000_0000, 32'd1));
        send_item(query_item(PT_TYPE2, 32'd1, 32'h8000_0000));
        send_item(query_item(PT_UNKNOWN, 32'hFFFF_FFFF, 32'h8000_0000));
        send_item(query_item(PT_GREEN, 32'd0, 32'd1));
        send_item(query_item(PT_RED, 32'd1, 32'd2));
        send_item(ignored_item());

        // Bead filter at its maximum and at a middle value
        settle();
        write_bead_floor(8'd255);
        send_item(query_item(PT_GREEN, 32'd1, 32'hFFFF_FFFF));
        send_item(query_item(PT_TYPE2, 32'd0, 32'hFFFF_FFFF));
        settle();
        write_bead_floor(8'd10);
        send_item(query_item(PT_UNKNOWN, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(query_item(PT_GREEN, 32'd1, 32'h8000_0000));

        // Clear keeps the filter; unsorted entries go through the same bisection
        send_item(clear_item());
        send_item(load_item(32'd50, 16'd500, 16'd501, 8'd20, 8'd20));
        send_item(load_item(32'd10, 16'd100, 16'd101, 8'd9, 8'd30));
        send_item(load_item(32'd30, 16'd300, 16'd301, 8'd30, 8'd30));
        send_item(query_item(PT_TYPE2, 32'd0, 32'd10));
        send_item(query_item(PT_GREEN, 32'd30, 32'd50));

        // Load a sorted table spread over the full address range and search it
        settle();
        write_bead_floor(8'd0);
        send_item(clear_item());
        load_sorted(40);
        for (i = 0; i < 20; i++)
            send_item(query_item(pick_type(), pick_address(), pick_address()));
        settle();

        // Random phases: new filter, clear, load, then queries
        phase = 0;
        while (random_items < RANDOM_ITEMS) begin
            settle();
            if (random_items >= RANDOM_ITEMS - QUIET_ITEMS) idling_on = 1'b0;
            if ($urandom_range(0, 1) == 0) begin
                r = $urandom_range(0, 99);
                if (r < 25) setting = 8'd0;
                else if (r < 50) setting = 8'd255;
                else if (r < 60) setting = 8'd1;
                else setting = 8'($urandom);
                write_bead_floor(setting);
            end
            if ($urandom_range(0, 4) != 0) begin
                send_item(clear_item());
                random_items++;
            end
            if ($urandom_range(0, 9) == 0) n = $urandom_range(100, 300);
            else n = $urandom_range(0, 24);
            if ($urandom_range(0, 6) == 0) load_scrambled(n);
            else load_sorted(n);
            // Hold off the receiver once so queries pile up against the input
            if (phase == 1) hold_off_request = 1'b1;
            run_queries(phase == 1 ? 30 : $urandom_range(4, 30));
            phase++;
        end
        settle();

        $display("Ran %0d loads (%0d dropped at full depth), %0d clears, %0d queries",
                 sb.loads, sb.dropped, sb.clears, sb.queries);
        $display("over %0d bead-minimum writes; %0d queries missed an address, %0d masked",
                 cfg_writes, sb.misses, sb.masked);
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
